[rtl/krasp_pkg.sv]
// Shared constants, types and state codes of the kept-range audio span planner.
package krasp_pkg;

  localparam int MAX_RANGES_DEF = 16;

  localparam int RATE_W = 19;
  localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;

  localparam int RANGE_MS_W = 32;
  localparam int START_W    = 47;
  localparam int FRAMES_W   = 16;
  localparam int EDIT_W     = 48;

  localparam int MS_PER_SEC  = 1000;
  localparam int REM_W       = $clog2(MS_PER_SEC);
  // quotient of a product by MS_PER_SEC is at least this many bits narrower
  localparam int QUOT_DROP_W = REM_W - 1;
  localparam int DIV_DIGITS  = 4;

  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_PLAN   = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_PLAN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [RANGE_MS_W-1:0]   range_in_ms;
    logic [RANGE_MS_W-1:0]   range_out_ms;
    logic [START_W-1:0]      packet_start_frame;
    logic [FRAMES_W-1:0]     packet_frames;
  } cmd_t;

  typedef struct packed {
    logic [EDIT_W-1:0]   edited_start_frame;
    logic [FRAMES_W-1:0] source_offset;
    logic [FRAMES_W-1:0] span_frames;
    logic                no_span;
    logic                last_span;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PASS,
    B_READ,
    B_LOAD,
    B_CONV_IN,
    B_CONV_OUT,
    B_CONV_BASE,
    B_CMP,
    B_SPAN,
    B_FINISH
  } back_state_t;

endpackage

[rtl/krasp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module krasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/krasp_fifo.sv]
// Small first-in first-out queue built from registers.
module krasp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/krasp_conv.sv]
// Milliseconds-to-frames unit: one multiply, then a digit-serial divide by 1000.
module krasp_conv #(
  parameter int MS_W = 36
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [MS_W-1:0]              ms,
  input  logic [krasp_pkg::RATE_W-1:0] rate,
  output logic                         done,
  output logic [MS_W+krasp_pkg::RATE_W-krasp_pkg::QUOT_DROP_W-1:0] frames
);

  localparam int PROD_W = MS_W + krasp_pkg::RATE_W;
  localparam int Q_W    = PROD_W - krasp_pkg::QUOT_DROP_W;
  localparam int DIG    = krasp_pkg::DIV_DIGITS;
  localparam int STEPS  = (PROD_W + DIG - 1) / DIG;
  localparam int PAD_W  = STEPS * DIG;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int REM_W  = krasp_pkg::REM_W;

  logic [PROD_W-1:0] prod;
  logic [PAD_W-1:0]  dividend_r, dividend_nxt;
  logic [PAD_W-1:0]  quot_r, quot_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  assign prod = PROD_W'(ms) * PROD_W'(rate);

  // Restoring division, DIG quotient bits per cycle.
  always_comb begin
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] rem_v;
    logic [DIG-1:0]   qbits;
    rem_v = rem_r;
    qbits = '0;
    for (int j = 0; j < DIG; j++) begin
      trial = {rem_v, dividend_r[PAD_W-1-j]};
      if (trial >= (REM_W + 1)'(krasp_pkg::MS_PER_SEC)) begin
        rem_v            = REM_W'(trial - (REM_W + 1)'(krasp_pkg::MS_PER_SEC));
        qbits[DIG-1-j]   = 1'b1;
      end else begin
        rem_v            = trial[REM_W-1:0];
      end
    end
    rem_nxt      = rem_v;
    dividend_nxt = dividend_r << DIG;
    quot_nxt     = {quot_r[PAD_W-DIG-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend_r <= PAD_W'(prod);
      rem_r      <= '0;
      quot_r     <= '0;
    end else if (busy_r) begin
      dividend_r <= dividend_nxt;
      rem_r      <= rem_nxt;
      quot_r     <= quot_nxt;
    end
  end

  assign done   = done_r;
  assign frames = quot_r[Q_W-1:0];

endmodule

[rtl/krasp_front.sv]
// Front end: accept input items, decode the action and queue commands.
module krasp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [1:0]                       in_action,
  input  logic [krasp_pkg::RANGE_MS_W-1:0] in_range_in_ms,
  input  logic [krasp_pkg::RANGE_MS_W-1:0] in_range_out_ms,
  input  logic [krasp_pkg::START_W-1:0]    in_packet_start_frame,
  input  logic [krasp_pkg::FRAMES_W-1:0]   in_packet_frames,
  output logic                             cmd_valid,
  input  logic                             cmd_pop,
  output krasp_pkg::cmd_t                  cmd
);

  localparam int CMD_W = $bits(krasp_pkg::cmd_t);

  krasp_pkg::cmd_t dec_cmd;
  logic            keep;
  logic            q_full, q_empty;
  logic [CMD_W-1:0] q_rdata;

  always_comb begin
    dec_cmd.range_in_ms        = in_range_in_ms;
    dec_cmd.range_out_ms       = in_range_out_ms;
    dec_cmd.packet_start_frame = in_packet_start_frame;
    dec_cmd.packet_frames      = in_packet_frames;
    keep                       = 1'b1;
    case (in_action)
      krasp_pkg::ACT_CLEAR:  dec_cmd.kind = krasp_pkg::CMD_CLEAR;
      krasp_pkg::ACT_APPEND: dec_cmd.kind = krasp_pkg::CMD_APPEND;
      krasp_pkg::ACT_PLAN:   dec_cmd.kind = krasp_pkg::CMD_PLAN;
      default: begin
        // unknown action: take it and drop it
        dec_cmd.kind = krasp_pkg::CMD_CLEAR;
        keep         = 1'b0;
      end
    endcase
  end

  krasp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (krasp_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && keep),
    .wdata (dec_cmd),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign in_full   = q_full;
  assign cmd_valid = !q_empty;
  assign cmd       = q_rdata;

endmodule

[rtl/krasp_back.sv]
// Back end: range table, range walk and span generation.
module krasp_back #(
  parameter int MAX_RANGES = krasp_pkg::MAX_RANGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [krasp_pkg::RATE_W-1:0] sample_rate,
  input  logic                         cmd_valid,
  output logic                         cmd_pop,
  input  krasp_pkg::cmd_t              cmd,
  output logic                         res_push,
  output krasp_pkg::res_t              res_data,
  input  logic                         res_full
);

  localparam int RMS_W  = krasp_pkg::RANGE_MS_W;
  localparam int IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam int MS_W   = RMS_W + $clog2(MAX_RANGES);
  localparam int Q_W    = MS_W + krasp_pkg::RATE_W - krasp_pkg::QUOT_DROP_W;
  localparam int EDIT_W = krasp_pkg::EDIT_W;
  localparam int CMP_W  = (Q_W > EDIT_W) ? Q_W : EDIT_W;
  localparam int FR_W   = krasp_pkg::FRAMES_W;
  localparam int RC_W   = krasp_pkg::RES_CNT_W;

  krasp_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [RC_W-1:0]              n_r, n_nxt;
  logic                         held_r, held_nxt;
  krasp_pkg::res_t              held_res_r, held_res_nxt;
  logic [krasp_pkg::START_W-1:0] pstart_r, pstart_nxt;
  logic [FR_W-1:0]              pframes_r, pframes_nxt;
  logic [EDIT_W-1:0]            pend_r, pend_nxt;
  logic [RMS_W-1:0]             in_ms_r, in_ms_nxt;
  logic [RMS_W-1:0]             out_ms_r, out_ms_nxt;
  logic [MS_W-1:0]              base_ms_r, base_ms_nxt;
  logic [Q_W-1:0]               rin_r, rin_nxt;
  logic [Q_W-1:0]               rout_r, rout_nxt;
  logic [EDIT_W-1:0]            base_adj_r, base_adj_nxt;
  logic [CMP_W-1:0]             i0_r, i0_nxt;
  logic [CMP_W-1:0]             i1_r, i1_nxt;

  logic                 ram_we;
  logic [2*RMS_W-1:0]   ram_rdata;
  logic                 conv_start, conv_done;
  logic [MS_W-1:0]      conv_ms;
  logic [Q_W-1:0]       conv_frames;

  logic                 room;
  logic                 last_idx;
  logic                 take;
  logic [RMS_W-1:0]     dur;
  logic [CMP_W-1:0]     ps_ext, rin_ext, pe_ext, rout_ext;
  krasp_pkg::res_t      span_res, pass_res, none_res;

  krasp_ram #(
    .WIDTH (2 * RMS_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({cmd.range_in_ms, cmd.range_out_ms}),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  krasp_conv #(
    .MS_W (MS_W)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .ms     (conv_ms),
    .rate   (sample_rate),
    .done   (conv_done),
    .frames (conv_frames)
  );

  assign room     = (count_r < CNT_W'(MAX_RANGES));
  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign take     = (i1_r > i0_r) && (n_r < RC_W'(krasp_pkg::MAX_RESULTS));
  assign dur      = (out_ms_r > in_ms_r) ? out_ms_r - in_ms_r : '0;
  assign ps_ext   = CMP_W'(pstart_r);
  assign rin_ext  = CMP_W'(rin_r);
  assign pe_ext   = CMP_W'(pend_r);
  assign rout_ext = CMP_W'(rout_r);

  always_comb begin
    span_res.edited_start_frame = base_adj_r + EDIT_W'(i0_r);
    span_res.source_offset      = FR_W'(i0_r - ps_ext);
    span_res.span_frames        = FR_W'(i1_r - i0_r);
    span_res.no_span            = 1'b0;
    span_res.last_span          = 1'b0;

    pass_res.edited_start_frame = EDIT_W'(pstart_r);
    pass_res.source_offset      = '0;
    pass_res.span_frames        = pframes_r;
    pass_res.no_span            = 1'b0;
    pass_res.last_span          = 1'b1;

    none_res.edited_start_frame = '0;
    none_res.source_offset      = '0;
    none_res.span_frames        = '0;
    none_res.no_span            = 1'b1;
    none_res.last_span          = 1'b1;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    held_nxt     = held_r;
    held_res_nxt = held_res_r;
    pstart_nxt   = pstart_r;
    pframes_nxt  = pframes_r;
    pend_nxt     = pend_r;
    in_ms_nxt    = in_ms_r;
    out_ms_nxt   = out_ms_r;
    base_ms_nxt  = base_ms_r;
    rin_nxt      = rin_r;
    rout_nxt     = rout_r;
    base_adj_nxt = base_adj_r;
    i0_nxt       = i0_r;
    i1_nxt       = i1_r;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    conv_start   = 1'b0;
    conv_ms      = base_ms_r;
    res_push     = 1'b0;
    res_data     = held_res_r;

    case (state_r)
      krasp_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            krasp_pkg::CMD_CLEAR: count_nxt = '0;
            krasp_pkg::CMD_APPEND: begin
              // drop the append when the table is full
              if (room) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            krasp_pkg::CMD_PLAN: begin
              pstart_nxt  = cmd.packet_start_frame;
              pframes_nxt = cmd.packet_frames;
              pend_nxt    = EDIT_W'(cmd.packet_start_frame) + EDIT_W'(cmd.packet_frames);
              base_ms_nxt = '0;
              idx_nxt     = '0;
              n_nxt       = '0;
              held_nxt    = 1'b0;
              if ((cmd.packet_frames == '0) || (sample_rate == '0)) begin
                state_nxt = krasp_pkg::B_FINISH;
              end else if (count_r == '0) begin
                state_nxt = krasp_pkg::B_PASS;
              end else begin
                state_nxt = krasp_pkg::B_READ;
              end
            end
            default: count_nxt = count_r;
          endcase
        end
      end

      krasp_pkg::B_PASS: begin
        if (!res_full) begin
          res_push  = 1'b1;
          res_data  = pass_res;
          state_nxt = krasp_pkg::B_IDLE;
        end
      end

      krasp_pkg::B_READ: state_nxt = krasp_pkg::B_LOAD;

      krasp_pkg::B_LOAD: begin
        in_ms_nxt  = ram_rdata[2*RMS_W-1:RMS_W];
        out_ms_nxt = ram_rdata[RMS_W-1:0];
        conv_start = 1'b1;
        conv_ms    = MS_W'(ram_rdata[2*RMS_W-1:RMS_W]);
        state_nxt  = krasp_pkg::B_CONV_IN;
      end

      krasp_pkg::B_CONV_IN: begin
        if (conv_done) begin
          rin_nxt    = conv_frames;
          conv_start = 1'b1;
          conv_ms    = MS_W'(out_ms_r);
          state_nxt  = krasp_pkg::B_CONV_OUT;
        end
      end

      krasp_pkg::B_CONV_OUT: begin
        if (conv_done) begin
          rout_nxt   = conv_frames;
          conv_start = 1'b1;
          conv_ms    = base_ms_r;
          state_nxt  = krasp_pkg::B_CONV_BASE;
        end
      end

      krasp_pkg::B_CONV_BASE: begin
        if (conv_done) begin
          // fold the range start into the base once, mod 2^48
          base_adj_nxt = EDIT_W'(conv_frames) - EDIT_W'(rin_r);
          base_ms_nxt  = base_ms_r + MS_W'(dur);
          state_nxt    = krasp_pkg::B_CMP;
        end
      end

      krasp_pkg::B_CMP: begin
        i0_nxt    = (ps_ext > rin_ext) ? ps_ext : rin_ext;
        i1_nxt    = (pe_ext < rout_ext) ? pe_ext : rout_ext;
        state_nxt = krasp_pkg::B_SPAN;
      end

      krasp_pkg::B_SPAN: begin
        if (!(take && held_r && res_full)) begin
          if (take) begin
            // release the previous span; it is not the last one
            if (held_r) begin
              res_push = 1'b1;
              res_data = held_res_r;
            end
            held_nxt     = 1'b1;
            held_res_nxt = span_res;
            n_nxt        = n_r + RC_W'(1);
          end
          if (last_idx) begin
            state_nxt = krasp_pkg::B_FINISH;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = krasp_pkg::B_READ;
          end
        end
      end

      krasp_pkg::B_FINISH: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (held_r) begin
            res_data           = held_res_r;
            res_data.last_span = 1'b1;
          end else begin
            res_data = none_res;
          end
          held_nxt  = 1'b0;
          state_nxt = krasp_pkg::B_IDLE;
        end
      end

      default: state_nxt = krasp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krasp_pkg::B_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      n_r     <= '0;
      held_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_res_r <= held_res_nxt;
    pstart_r   <= pstart_nxt;
    pframes_r  <= pframes_nxt;
    pend_r     <= pend_nxt;
    in_ms_r    <= in_ms_nxt;
    out_ms_r   <= out_ms_nxt;
    base_ms_r  <= base_ms_nxt;
    rin_r      <= rin_nxt;
    rout_r     <= rout_nxt;
    base_adj_r <= base_adj_nxt;
    i0_r       <= i0_nxt;
    i1_r       <= i1_nxt;
  end

endmodule

[rtl/kept_range_audio_span_planner.sv]
// Top level of the kept-range audio span planner: ports, rate register, result queue.
//
//   channel   direction  handshake               payload
//   in_*      input      in_push / in_full       action, range in/out ms, packet start/frames
//   out_*     output     out_pop / out_empty     edited start, offset, span frames, flags
//   cfg_*     input      cfg_valid / cfg_ready   sample rate (19 bits)
//
// Clear and append commands are handled in the back end's idle state. A plan
// with packet frames and a nonzero rate walks every stored range; the shared
// ms-to-frames divider runs three times per range (in, out, edited base).
// Reset (rst_n low, synchronous) empties the range table and both queues and
// loads the sample rate with 48000. A full result queue stalls the back end;
// the command queue keeps taking items until it fills.
module kept_range_audio_span_planner #(
  parameter int MAX_RANGES = krasp_pkg::MAX_RANGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_push,
  output logic                             in_full,
  input  logic [1:0]                       in_action,
  input  logic [krasp_pkg::RANGE_MS_W-1:0] in_range_in_ms,
  input  logic [krasp_pkg::RANGE_MS_W-1:0] in_range_out_ms,
  input  logic [krasp_pkg::START_W-1:0]    in_packet_start_frame,
  input  logic [krasp_pkg::FRAMES_W-1:0]   in_packet_frames,

  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [krasp_pkg::EDIT_W-1:0]     out_edited_start_frame,
  output logic [krasp_pkg::FRAMES_W-1:0]   out_source_offset,
  output logic [krasp_pkg::FRAMES_W-1:0]   out_span_frames,
  output logic                             out_no_span,
  output logic                             out_last_span,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [krasp_pkg::RATE_W-1:0]     cfg_sample_rate
);

  localparam int RES_W = $bits(krasp_pkg::res_t);

  logic [krasp_pkg::RATE_W-1:0] rate_r;

  logic            cmd_valid;
  logic            cmd_pop;
  krasp_pkg::cmd_t cmd;

  logic            res_push;
  krasp_pkg::res_t res_data;
  logic            res_full;
  logic [RES_W-1:0] res_q_rdata;
  krasp_pkg::res_t res_head;

  // Rate register: always ready, a transaction lands on the next edge.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= krasp_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_r <= cfg_sample_rate;
    end
  end

  // Front end: decode each input transaction into a queued command; unknown actions are dropped.
  krasp_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_action             (in_action),
    .in_range_in_ms        (in_range_in_ms),
    .in_range_out_ms       (in_range_out_ms),
    .in_packet_start_frame (in_packet_start_frame),
    .in_packet_frames      (in_packet_frames),
    .cmd_valid             (cmd_valid),
    .cmd_pop               (cmd_pop),
    .cmd                   (cmd)
  );

  // Back end: owns the range table and walks it for each plan command.
  krasp_back #(
    .MAX_RANGES (MAX_RANGES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_rate (rate_r),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .res_push    (res_push),
    .res_data    (res_data),
    .res_full    (res_full)
  );

  // Result queue: decouples span generation from the consumer's pops.
  krasp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (krasp_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q_rdata),
    .empty (out_empty)
  );

  assign res_head               = res_q_rdata;
  assign out_edited_start_frame = res_head.edited_start_frame;
  assign out_source_offset      = res_head.source_offset;
  assign out_span_frames        = res_head.span_frames;
  assign out_no_span            = res_head.no_span;
  assign out_last_span          = res_head.last_span;

endmodule
